/* rtl/tdpt_pkg.sv */
// shared types and constants for the trial division prime test
`timescale 1ns / 1ps

package tdpt_pkg;

   // transfer codes returned with each result word
   localparam logic [1:0] XFER_ONE   = 2'd1;
   localparam logic [1:0] XFER_TWO   = 2'd2;
   localparam logic [1:0] XFER_THREE = 2'd3;

   // status handed back from the remainder unit to the sequencer
   typedef struct packed {
      logic done;
      logic rem_zero;
   } tdpt_rem_status_type;

endpackage

/* rtl/tdpt_rem.sv */
// bit-serial restoring remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps

module tdpt_rem #(
   parameter int NUM_WIDTH = 40
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         go,
   input  logic [NUM_WIDTH-1:0]         dividend,
   input  logic [NUM_WIDTH-1:0]         divisor,
   output tdpt_pkg::tdpt_rem_status_type status
);

   localparam int CNT_W = $clog2(NUM_WIDTH + 1);

   logic                 running_ff, running_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [NUM_WIDTH-1:0] num_ff, num_in;
   logic [NUM_WIDTH-1:0] div_ff, div_in;
   logic [NUM_WIDTH-1:0] rem_ff, rem_in;
   logic [NUM_WIDTH:0]   shifted;
   logic [NUM_WIDTH:0]   div_ext;
   logic                 fits;

   // one restoring step: shift in next dividend bit, subtract if it fits
   always_comb begin
      shifted = {rem_ff, num_ff[NUM_WIDTH-1]};
      div_ext = {1'b0, div_ff};
      fits    = (shifted >= div_ext);
   end

   // step control
   always_comb begin
      running_in = running_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      num_in     = num_ff;
      div_in     = div_ff;
      rem_in     = rem_ff;
      if (go) begin
         running_in = 1'b1;
         cnt_in     = CNT_W'(NUM_WIDTH);
         num_in     = dividend;
         div_in     = divisor;
         rem_in     = '0;
      end else if (running_ff) begin
         num_in = {num_ff[NUM_WIDTH-2:0], 1'b0};
         rem_in = fits ? NUM_WIDTH'(shifted - div_ext) : NUM_WIDTH'(shifted);
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         cnt_ff     <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      num_ff <= num_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign status.done     = done_ff;
   assign status.rem_zero = (rem_ff == '0);

endmodule

/* rtl/trial_division_prime_test.sv */
// trial division primality test: sequencer over a shared remainder unit
// numbers below 2, 2 itself and even numbers are decided in the check state; otherwise each
//   odd divisor 3, 5, 7, ... up to sqrt(number) takes one pass of the remainder unit
// throughput: one word at a time; busy stays high until the result strobe
// the remainder unit resolves one dividend bit per cycle
// reset: synchronous, active high, returns the sequencer to idle; results cannot be stalled
`timescale 1ns / 1ps

module trial_division_prime_test #(
   parameter int NUM_WIDTH = 40
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [NUM_WIDTH-1:0] req_number,
   output logic                 rsp_valid,
   output logic                 rsp_is_prime,
   output logic [1:0]           rsp_min_transfer
);

   localparam int SQ_W = NUM_WIDTH + 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_BOUND,
      ST_WAIT,
      ST_NEXT
   } state_type;

   state_type            state_ff;
   logic [NUM_WIDTH-1:0] num_ff;
   logic [NUM_WIDTH-1:0] div_ff;
   logic [SQ_W-1:0]      sq_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_prime_ff;
   logic [1:0]           rsp_xfer_ff;
   logic                 rem_go;
   logic [SQ_W-1:0]      num_ext;
   logic [SQ_W-1:0]      sq_step;
   logic                 is_three;

   tdpt_pkg::tdpt_rem_status_type rem_status;

   // shared remainder unit
   tdpt_rem #(
      .NUM_WIDTH(NUM_WIDTH)
   ) u_rem (
      .clock   (clock),
      .reset   (reset),
      .go      (rem_go),
      .dividend(num_ff),
      .divisor (div_ff),
      .status  (rem_status)
   );

   // bound and square update: (d+2)^2 = d^2 + 4d + 4
   always_comb begin
      num_ext  = {2'b00, num_ff};
      sq_step  = {div_ff, 2'b00} + SQ_W'(4);
      is_three = (num_ff == NUM_WIDTH'(3));
      rem_go   = (state_ff == ST_BOUND) && (sq_ff <= num_ext);
   end

   // sequencer and registered result word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               rsp_valid_ff <= 1'b0;
               if (start) begin
                  num_ff   <= req_number;
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               div_ff <= NUM_WIDTH'(3);
               sq_ff  <= SQ_W'(9);
               if (num_ff == NUM_WIDTH'(2)) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_prime_ff <= 1'b1;
                  rsp_xfer_ff  <= tdpt_pkg::XFER_TWO;
                  state_ff     <= ST_IDLE;
               end else if (num_ff < NUM_WIDTH'(2) || !num_ff[0]) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_prime_ff <= 1'b0;
                  rsp_xfer_ff  <= tdpt_pkg::XFER_ONE;
                  state_ff     <= ST_IDLE;
               end else begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_BOUND;
               end
            end
            ST_BOUND: begin
               if (rem_go) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_WAIT;
               end else begin
                  rsp_valid_ff <= 1'b1;
                  rsp_prime_ff <= 1'b1;
                  rsp_xfer_ff  <= is_three ? tdpt_pkg::XFER_THREE : tdpt_pkg::XFER_TWO;
                  state_ff     <= ST_IDLE;
               end
            end
            ST_WAIT: begin
               if (rem_status.done) begin
                  if (rem_status.rem_zero) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_prime_ff <= 1'b0;
                     rsp_xfer_ff  <= tdpt_pkg::XFER_ONE;
                     state_ff     <= ST_IDLE;
                  end else begin
                     rsp_valid_ff <= 1'b0;
                     state_ff     <= ST_NEXT;
                  end
               end else begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            ST_NEXT: begin
               rsp_valid_ff <= 1'b0;
               sq_ff        <= sq_ff + sq_step;
               div_ff       <= div_ff + NUM_WIDTH'(2);
               state_ff     <= ST_BOUND;
            end
            default: begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_prime     = rsp_prime_ff;
   assign rsp_min_transfer = rsp_xfer_ff;

endmodule
